// File: design/pjn_pkg.sv
// Shared constants, codes and controller/datapath interface types for the path join block.
package pjn_pkg;

	// Buffer capacity in characters; the path holds at most BUF_CAP-1 characters.
	localparam int BUF_CAP = 64;
	localparam int AW      = (BUF_CAP > 2) ? $clog2(BUF_CAP) : 1;

	typedef logic [AW-1:0] fill_t;

	localparam fill_t FILL_MAX = AW'(BUF_CAP - 1);
	localparam fill_t FILL_ONE = AW'(1);

	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	localparam logic [1:0] REQ_BASE = 2'd0;
	localparam logic [1:0] REQ_REL  = 2'd1;
	localparam logic [1:0] REQ_END  = 2'd2;

	// Source of a character appended to the buffer.
	localparam logic [1:0] SEL_SLASH = 2'd0;
	localparam logic [1:0] SEL_C0    = 2'd1;
	localparam logic [1:0] SEL_C1    = 2'd2;
	localparam logic [1:0] SEL_CIN   = 2'd3;

	typedef struct packed {
		logic       latch;
		logic       base_wr;
		logic       rel_start;
		logic       hold;
		logic       put;
		logic [1:0] put_sel;
		logic       comp_clr;
		logic       comp_set3;
		logic       pop_rd;
		logic       pop_chk;
		logic       emit_init;
		logic       emit_rd;
		logic       out_load;
		logic       out_sel_one;
		logic       end_clr;
	} pjn_cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       cin_zero;
		logic       cin_slash;
		logic       phase;
		logic [1:0] comp_len;
		logic       c0_dot;
		logic       c1_dot;
		logic       ovf;
		logic       fill_zero;
		logic       pop_more;
		logic       emit_last;
		logic       out_free;
	} pjn_stat_t;

endpackage

// File: design/pjn_datapath.sv
// Datapath: path buffer memory, fill count, component holding registers and output register.
module pjn_datapath import pjn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pjn_cmd_t   cmd,
	output pjn_stat_t  st,
	input  logic [1:0] req_type,
	input  logic [7:0] ch,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] ch_out,
	output logic       status,
	output logic       last
);

	logic [7:0] mem [BUF_CAP];
	logic [7:0] rdata_q;

	logic [1:0] req_q;
	logic [7:0] cin_q;
	logic [7:0] c0_q;
	logic [7:0] c1_q;
	fill_t      fill_q;
	fill_t      k_q;
	logic       phase_q;
	logic [1:0] comp_q;
	logic       ovf_q;

	logic       out_valid_q;
	logic [7:0] ch_out_q;
	logic       status_q;
	logic       last_q;

	logic       fill_gt1;
	logic       fill_full;
	logic       put_go;
	logic       put_ok;
	logic       put_ovf;
	logic [7:0] put_data;
	logic       base_ok;
	logic       start_wr;
	logic       we;
	fill_t      waddr;
	logic [7:0] wdata;
	logic       re;
	fill_t      raddr;
	logic       out_free;

	assign fill_gt1  = fill_q > FILL_ONE;
	assign fill_full = fill_q == FILL_MAX;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		case (cmd.put_sel)
			SEL_SLASH: put_data = CHAR_SLASH;
			SEL_C0:    put_data = c0_q;
			SEL_C1:    put_data = c1_q;
			default:   put_data = cin_q;
		endcase
	end

	// A separator goes in only when the buffer holds more than the root.
	assign put_go   = cmd.put && !ovf_q && (cmd.put_sel != SEL_SLASH || fill_gt1);
	assign put_ok   = put_go && !fill_full;
	assign put_ovf  = put_go && fill_full;
	assign base_ok  = cmd.base_wr && !phase_q && cin_q != CHAR_NUL && !fill_full;
	assign start_wr = cmd.rel_start && (cin_q == CHAR_SLASH || fill_q == '0);

	always_comb begin
		we    = 1'b0;
		waddr = fill_q;
		wdata = cin_q;
		if (base_ok) begin
			we = 1'b1;
		end else if (start_wr) begin
			we    = 1'b1;
			waddr = '0;
			wdata = CHAR_SLASH;
		end else if (put_ok) begin
			we    = 1'b1;
			wdata = put_data;
		end
	end

	assign re    = cmd.pop_rd || cmd.emit_rd;
	assign raddr = cmd.pop_rd ? (fill_q - FILL_ONE) : k_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Payload holding registers.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_type;
			cin_q <= ch;
		end
		if (cmd.hold) begin
			if (comp_q == 2'd0) begin
				c0_q <= cin_q;
			end else begin
				c1_q <= cin_q;
			end
		end
		if (cmd.out_load) begin
			if (cmd.out_sel_one) begin
				ch_out_q <= ovf_q ? CHAR_NUL : CHAR_SLASH;
				status_q <= ovf_q;
				last_q   <= 1'b1;
			end else begin
				ch_out_q <= rdata_q;
				status_q <= 1'b0;
				last_q   <= st.emit_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			k_q         <= '0;
			phase_q     <= 1'b0;
			comp_q      <= 2'd0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.end_clr) begin
				fill_q  <= '0;
				phase_q <= 1'b0;
				comp_q  <= 2'd0;
				ovf_q   <= 1'b0;
			end else begin
				if (base_ok || put_ok) begin
					fill_q <= fill_q + FILL_ONE;
				end else if (start_wr) begin
					fill_q <= FILL_ONE;
				end else if (cmd.pop_chk && fill_gt1) begin
					fill_q <= fill_q - FILL_ONE;
				end
				if (cmd.rel_start) begin
					phase_q <= 1'b1;
				end
				if (put_ovf) begin
					ovf_q <= 1'b1;
				end
				if (cmd.comp_clr) begin
					comp_q <= 2'd0;
				end else if (cmd.comp_set3) begin
					comp_q <= 2'd3;
				end else if (cmd.hold) begin
					comp_q <= comp_q + 2'd1;
				end
			end
			if (cmd.emit_init) begin
				k_q <= '0;
			end else if (cmd.out_load && !cmd.out_sel_one) begin
				k_q <= k_q + FILL_ONE;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st.req       = req_q;
		st.cin_zero  = cin_q == CHAR_NUL;
		st.cin_slash = cin_q == CHAR_SLASH;
		st.phase     = phase_q;
		st.comp_len  = comp_q;
		st.c0_dot    = c0_q == CHAR_DOT;
		st.c1_dot    = c1_q == CHAR_DOT;
		st.ovf       = ovf_q;
		st.fill_zero = fill_q == '0;
		st.pop_more  = fill_gt1 && rdata_q != CHAR_SLASH;
		st.emit_last = k_q == (fill_q - FILL_ONE);
		st.out_free  = out_free;
	end

	assign out_valid = out_valid_q;
	assign ch_out    = ch_out_q;
	assign status    = status_q;
	assign last      = last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("fill count beyond capacity");

	a_comp_phase: assert property (@(posedge clk) disable iff (!arst_n)
		comp_q != 2'd0 |-> phase_q)
		else $error("component in progress outside relative phase");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("output register overwritten while stalled");

	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.end_clr |=> (fill_q == '0 && !ovf_q && !phase_q))
		else $error("state not cleared after end of request");

endmodule

// File: design/pjn_ctrl.sv
// Controller: sequences buffer appends, component pops and result emission.
module pjn_ctrl import pjn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  pjn_stat_t st,
	output pjn_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_REL      = 4'd2;
	localparam logic [3:0] S_PSEP     = 4'd3;
	localparam logic [3:0] S_PC0      = 4'd4;
	localparam logic [3:0] S_PC1      = 4'd5;
	localparam logic [3:0] S_PCIN     = 4'd6;
	localparam logic [3:0] S_POP_RD   = 4'd7;
	localparam logic [3:0] S_POP_CHK  = 4'd8;
	localparam logic [3:0] S_EMIT_SEL = 4'd9;
	localparam logic [3:0] S_E_RD     = 4'd10;
	localparam logic [3:0] S_E_OUT    = 4'd11;
	localparam logic [3:0] S_E_ONE    = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [3:0] done_next;
	logic [3:0] fin_next;
	logic       fin_done;
	logic       finishing;
	pjn_cmd_t   rel_cmd;
	logic [3:0] rel_next;

	assign finishing = st.cin_slash || st.req == REQ_END;
	assign done_next = (st.req == REQ_END) ? S_EMIT_SEL : S_IDLE;

	// Close the current component.
	always_comb begin
		fin_done = 1'b0;
		fin_next = done_next;
		if (st.comp_len == 2'd1 && !st.c0_dot) begin
			fin_next = S_PSEP;
		end else if (st.comp_len == 2'd2 && st.c0_dot && st.c1_dot) begin
			if (st.ovf) begin
				fin_done = 1'b1;
			end else begin
				fin_next = S_POP_RD;
			end
		end else if (st.comp_len == 2'd2) begin
			fin_next = S_PSEP;
		end else begin
			fin_done = 1'b1;
		end
	end

	// One relative character, once the relative phase is open.
	always_comb begin
		rel_cmd  = '0;
		rel_next = S_IDLE;
		if (st.cin_slash) begin
			rel_cmd.comp_clr = fin_done;
			rel_next         = fin_next;
		end else begin
			case (st.comp_len)
				2'd0, 2'd1: begin
					rel_cmd.hold = 1'b1;
				end
				2'd2: begin
					rel_next = S_PSEP;
				end
				default: begin
					rel_cmd.put     = 1'b1;
					rel_cmd.put_sel = SEL_CIN;
				end
			endcase
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.latch = in_valid;
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (st.req)
					REQ_BASE: begin
						cmd.base_wr = 1'b1;
						state_d     = S_IDLE;
					end
					REQ_REL: begin
						if (st.cin_zero) begin
							state_d = S_IDLE;
						end else if (!st.phase) begin
							cmd.rel_start = 1'b1;
							state_d       = S_REL;
						end else begin
							cmd     = rel_cmd;
							state_d = rel_next;
						end
					end
					REQ_END: begin
						cmd.comp_clr = fin_done;
						state_d      = fin_next;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_REL: begin
				cmd     = rel_cmd;
				state_d = rel_next;
			end
			S_PSEP: begin
				cmd.put     = 1'b1;
				cmd.put_sel = SEL_SLASH;
				state_d     = S_PC0;
			end
			S_PC0: begin
				cmd.put     = 1'b1;
				cmd.put_sel = SEL_C0;
				if (st.comp_len == 2'd1) begin
					cmd.comp_clr = 1'b1;
					state_d      = done_next;
				end else begin
					state_d = S_PC1;
				end
			end
			S_PC1: begin
				cmd.put     = 1'b1;
				cmd.put_sel = SEL_C1;
				if (finishing) begin
					cmd.comp_clr = 1'b1;
					state_d      = done_next;
				end else begin
					state_d = S_PCIN;
				end
			end
			S_PCIN: begin
				cmd.put       = 1'b1;
				cmd.put_sel   = SEL_CIN;
				cmd.comp_set3 = 1'b1;
				state_d       = S_IDLE;
			end
			S_POP_RD: begin
				cmd.pop_rd = 1'b1;
				state_d    = S_POP_CHK;
			end
			S_POP_CHK: begin
				cmd.pop_chk = 1'b1;
				if (st.pop_more) begin
					state_d = S_POP_RD;
				end else begin
					cmd.comp_clr = 1'b1;
					state_d      = done_next;
				end
			end
			S_EMIT_SEL: begin
				if (st.ovf || st.fill_zero) begin
					state_d = S_E_ONE;
				end else begin
					cmd.emit_init = 1'b1;
					state_d       = S_E_RD;
				end
			end
			S_E_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = S_E_OUT;
			end
			S_E_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					if (st.emit_last) begin
						cmd.end_clr = 1'b1;
						state_d     = S_IDLE;
					end else begin
						state_d = S_E_RD;
					end
				end
			end
			S_E_ONE: begin
				if (st.out_free) begin
					cmd.out_load    = 1'b1;
					cmd.out_sel_one = 1'b1;
					cmd.end_clr     = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = state_q != S_IDLE;

endmodule

// File: design/path_join_normalizer_top.sv
// Top level of the path join and normalize block: controller plus datapath.
//
// Input channel (in_valid / in_stall, req_type, ch): one character per beat.
// req_type selects a base directory character, a relative path character or
// the end of the request; ch is ignored on the end beat.
// Output channel (out_valid / out_stall, ch_out, status, last): after the end
// beat the block sends the joined, normalized path one character per beat,
// with last on the final one, or a single beat with status set and ch_out
// zero when the path outgrew the buffer. An empty path comes out as "/".
// Sequence: each character is accepted, then decoded; the first relative
// one also opens the relative phase. Closing a short component or flushing
// one at its third character appends separator and held characters in turn.
// A ".." walks the buffer back through the single read port, a read then a
// check per character looked at. The end beat closes the last component,
// then sends each character by a registered memory read and an output load.
// in_stall is low only while the block waits for a new beat; a result still
// waiting in the output register does not block the next input beat.
// If out_stall is high, emission holds with the pending beat unchanged.
// Reset (arst_n low) empties the path, clears the error flag and drops any
// pending output beat; the buffer contents need no clearing.
module path_join_normalizer_top import pjn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] ch,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] ch_out,
	output logic       status,
	output logic       last
);

	pjn_cmd_t  cmd;
	pjn_stat_t st;

	// Sequence each beat's work.
	pjn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// Hold the path and drive the result beats.
	pjn_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.req_type  (req_type),
		.ch        (ch),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ch_out    (ch_out),
		.status    (status),
		.last      (last)
	);

endmodule
